FILE: rtl/bls_pkg.sv
// Shared types and constants for the Bresenham line stepper.
package bls_pkg;

    localparam int COORD_BITS = 12;
    localparam int DELTA_BITS = COORD_BITS + 2;
    localparam int ERR_BITS   = COORD_BITS + 3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic STYLE_SOLID  = 1'b0;
    localparam logic STYLE_DASHED = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
    } req_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  plot;
        logic                  last;
    } pix_t;

endpackage

FILE: rtl/bresenham_line_stepper.sv
// Top level of the Bresenham line stepper: request port, pixel port, style register.
//
// Usage: a request item with cmd set to load latches two endpoints and
// starts a new line; it gives no pixel. Each request item with cmd set to
// step emits one pixel item of the active line (coordinates, plot, last)
// and gives nothing when no line is active. After the pixel flagged last
// the line ends. The cfg channel writes the one style bit (solid or
// dashed); write it only while the block is idle.
// A step item's pixel is registered in the output register, or in the skid
// register when the output waits. Throughput: one request item per cycle while
// req_stall is low, set by the single pass through the walk logic between the state registers.
// The pixel port has an output register and a skid register, so a request
// is still taken while one pixel waits; req_stall rises only when both hold
// a pixel, and falls once the receiver takes one.
// Reset clears the style to solid, ends any line and empties the output.
module bresenham_line_stepper
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bls_pkg::req_t req,
    output logic          pix_valid,
    input  logic          pix_stall,
    output bls_pkg::pix_t pix,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);

    logic          style_reg;
    logic          out_valid_reg;
    logic          skid_valid_reg;
    bls_pkg::pix_t out_reg;
    bls_pkg::pix_t skid_reg;

    logic          item_fire;
    logic          out_fire;
    logic          res_valid;
    bls_pkg::pix_t res;

    assign cfg_ready = 1'b1;
    assign req_stall = skid_valid_reg;
    assign item_fire = req_valid && !req_stall;
    assign out_fire  = out_valid_reg && !pix_stall;

    bls_walk u_walk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_fire  (item_fire),
        .req        (req),
        .line_style (style_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_reg <= bls_pkg::STYLE_SOLID;
        end
        else if (cfg_valid && cfg_ready)
        begin
            style_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

`ifndef SYNTH
    // The skid register only fills behind a waiting output register.
    a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a pixel with the output empty");

    // A pixel produced while the output stalls lands in the skid register.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid_reg && pix_stall) |=> skid_valid_reg)
        else $error("pixel lost while the output stalled");

    // The skid register drains when the receiver takes the waiting pixel.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !pix_stall) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid register did not drain");
`endif

endmodule

FILE: rtl/bls_walk.sv
// Line walk state: load setup, per-step pixel result and state advance.
module bls_walk
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_fire,
    input  bls_pkg::req_t req,
    input  logic         line_style,
    output logic         res_valid,
    output bls_pkg::pix_t res
);

    logic                                  active_reg, active_next;
    logic                                  x_major_reg, x_major_next;
    logic [bls_pkg::COORD_BITS-1:0]        major_pos_reg, major_pos_next;
    logic [bls_pkg::COORD_BITS-1:0]        major_stop_reg, major_stop_next;
    logic [bls_pkg::COORD_BITS-1:0]        minor_pos_reg, minor_pos_next;
    logic                                  minor_neg_reg, minor_neg_next;
    logic signed [bls_pkg::ERR_BITS-1:0]   error_reg, error_next;
    logic [bls_pkg::DELTA_BITS-1:0]        major_twice_reg, major_twice_next;
    logic [bls_pkg::DELTA_BITS-1:0]        minor_twice_reg, minor_twice_next;
    logic [1:0]                            dash_reg, dash_next;

    // Load setup
    logic [bls_pkg::COORD_BITS-1:0] adx, ady, maj_abs, min_abs;
    logic [bls_pkg::COORD_BITS-1:0] a_maj, b_maj, a_min, b_min, s_min, e_min;
    logic                           load_x_major, a_first;

    // Step
    logic                                is_last;
    logic signed [bls_pkg::ERR_BITS-1:0] err_sum;
    logic                                is_load, is_step;

    assign is_load = item_fire && (req.cmd == bls_pkg::CMD_LOAD);
    assign is_step = item_fire && (req.cmd == bls_pkg::CMD_STEP) && active_reg;

    always_comb
    begin
        adx = (req.x_start >= req.x_end) ? (req.x_start - req.x_end)
                                         : (req.x_end - req.x_start);
        ady = (req.y_start >= req.y_end) ? (req.y_start - req.y_end)
                                         : (req.y_end - req.y_start);
        load_x_major = adx > ady;
        if (load_x_major)
        begin
            a_maj   = req.x_start;
            b_maj   = req.x_end;
            a_min   = req.y_start;
            b_min   = req.y_end;
            maj_abs = adx;
            min_abs = ady;
        end
        else
        begin
            a_maj   = req.y_start;
            b_maj   = req.y_end;
            a_min   = req.x_start;
            b_min   = req.x_end;
            maj_abs = ady;
            min_abs = adx;
        end
        // The walk always begins at the larger major coordinate.
        a_first = a_maj >= b_maj;
        s_min   = a_first ? a_min : b_min;
        e_min   = a_first ? b_min : a_min;
    end

    assign is_last = major_pos_reg == major_stop_reg;
    assign err_sum = error_reg + $signed({1'b0, minor_twice_reg});

    always_comb
    begin
        active_next      = active_reg;
        x_major_next     = x_major_reg;
        major_pos_next   = major_pos_reg;
        major_stop_next  = major_stop_reg;
        minor_pos_next   = minor_pos_reg;
        minor_neg_next   = minor_neg_reg;
        error_next       = error_reg;
        major_twice_next = major_twice_reg;
        minor_twice_next = minor_twice_reg;
        dash_next        = dash_reg;
        if (is_load)
        begin
            active_next      = 1'b1;
            x_major_next     = load_x_major;
            major_pos_next   = a_first ? a_maj : b_maj;
            major_stop_next  = a_first ? b_maj : a_maj;
            minor_pos_next   = s_min;
            minor_neg_next   = e_min < s_min;
            error_next       = -$signed({3'b000, maj_abs});
            major_twice_next = {1'b0, maj_abs, 1'b0};
            minor_twice_next = {1'b0, min_abs, 1'b0};
            dash_next        = 2'd0;
        end
        else if (is_step)
        begin
            dash_next = dash_reg + 2'd1;
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg - 1'b1;
                if (err_sum >= 0)
                begin
                    minor_pos_next = minor_neg_reg ? (minor_pos_reg - 1'b1)
                                                   : (minor_pos_reg + 1'b1);
                    error_next     = err_sum - $signed({1'b0, major_twice_reg});
                end
                else
                begin
                    error_next = err_sum;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            x_major_reg     <= 1'b0;
            major_pos_reg   <= '0;
            major_stop_reg  <= '0;
            minor_pos_reg   <= '0;
            minor_neg_reg   <= 1'b0;
            error_reg       <= '0;
            major_twice_reg <= '0;
            minor_twice_reg <= '0;
            dash_reg        <= 2'd0;
        end
        else
        begin
            active_reg      <= active_next;
            x_major_reg     <= x_major_next;
            major_pos_reg   <= major_pos_next;
            major_stop_reg  <= major_stop_next;
            minor_pos_reg   <= minor_pos_next;
            minor_neg_reg   <= minor_neg_next;
            error_reg       <= error_next;
            major_twice_reg <= major_twice_next;
            minor_twice_reg <= minor_twice_next;
            dash_reg        <= dash_next;
        end
    end

    assign res_valid   = is_step;
    assign res.pixel_x = x_major_reg ? major_pos_reg : minor_pos_reg;
    assign res.pixel_y = x_major_reg ? minor_pos_reg : major_pos_reg;
    assign res.plot    = (line_style == bls_pkg::STYLE_SOLID) || !dash_reg[1];
    assign res.last    = is_last;

`ifndef SYNTH
    // The line ends right after its final pixel.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (is_step && is_last) |=> !active_reg)
        else $error("line still active after its final pixel");

    // A load starts a fresh line with the stipple at its first phase.
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        is_load |=> (active_reg && dash_reg == 2'd0))
        else $error("load did not start a line");

    // Between steps the error term is never positive.
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (error_reg <= 0))
        else $error("error term out of range");
`endif

endmodule

FILE: test/bresenham_line_stepper_test.sv
// Self-checking testbench for the Bresenham line stepper.
module bresenham_line_stepper_test;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 150;
    localparam logic [bls_pkg::COORD_BITS-1:0] COORD_MAX = '1;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    bls_pkg::req_t  req = '0;
    logic           pix_valid;
    logic           pix_stall;
    bls_pkg::pix_t  pix;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic           cfg_data = 1'b0;

    // Walk state of the line as the testbench expects it.
    logic                                style_q = bls_pkg::STYLE_SOLID;
    logic                                line_on = 1'b0;
    logic                                x_major = 1'b0;
    logic [bls_pkg::COORD_BITS-1:0]      major_at = '0;
    logic [bls_pkg::COORD_BITS-1:0]      major_end = '0;
    logic [bls_pkg::COORD_BITS-1:0]      minor_at = '0;
    logic                                minor_down = 1'b0;
    logic signed [bls_pkg::ERR_BITS-1:0] err_acc = '0;
    logic [bls_pkg::DELTA_BITS-1:0]      major_twice = '0;
    logic [bls_pkg::DELTA_BITS-1:0]      minor_twice = '0;
    logic [1:0]                          dash_phase = '0;

    bls_pkg::pix_t expected_pixels[$];
    int            errors = 0;
    int            cycles = 0;
    logic          calm = 1'b0;
    logic          hold_pix = 1'b0;

    bresenham_line_stepper DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** bresenham_line_stepper: FAILED **");
            $finish;
        end
    end

    task automatic walk_line(input bls_pkg::req_t r);
        logic [bls_pkg::COORD_BITS-1:0] adx, ady, a_maj, b_maj, a_min, b_min, s_min, e_min;
        bls_pkg::pix_t p;
        if (r.cmd == bls_pkg::CMD_LOAD)
        begin
            adx = (r.x_start > r.x_end) ? r.x_start - r.x_end : r.x_end - r.x_start;
            ady = (r.y_start > r.y_end) ? r.y_start - r.y_end : r.y_end - r.y_start;
            x_major = adx > ady;
            if (x_major)
            begin
                a_maj = r.x_start;
                b_maj = r.x_end;
                a_min = r.y_start;
                b_min = r.y_end;
                major_twice = {1'b0, adx, 1'b0};
                minor_twice = {1'b0, ady, 1'b0};
            end
            else
            begin
                a_maj = r.y_start;
                b_maj = r.y_end;
                a_min = r.x_start;
                b_min = r.x_end;
                major_twice = {1'b0, ady, 1'b0};
                minor_twice = {1'b0, adx, 1'b0};
            end
            // The walk always runs from the larger major coordinate downward.
            if (a_maj >= b_maj)
            begin
                major_at = a_maj;
                major_end = b_maj;
                s_min = a_min;
                e_min = b_min;
            end
            else
            begin
                major_at = b_maj;
                major_end = a_maj;
                s_min = b_min;
                e_min = a_min;
            end
            minor_at = s_min;
            minor_down = e_min < s_min;
            err_acc = '0 - bls_pkg::ERR_BITS'(major_twice >> 1);
            dash_phase = '0;
            line_on = 1'b1;
        end
        else if (line_on)
        begin
            p.last = (major_at == major_end);
            p.plot = (style_q == bls_pkg::STYLE_SOLID) || !dash_phase[1];
            p.pixel_x = x_major ? major_at : minor_at;
            p.pixel_y = x_major ? minor_at : major_at;
            expected_pixels.push_back(p);
            dash_phase = dash_phase + 2'd1;
            if (p.last)
                line_on = 1'b0;
            else
            begin
                major_at = major_at - 1'b1;
                err_acc = err_acc + bls_pkg::ERR_BITS'(minor_twice);
                if (!err_acc[bls_pkg::ERR_BITS-1])
                begin
                    minor_at = minor_down ? minor_at - 1'b1 : minor_at + 1'b1;
                    err_acc = err_acc - bls_pkg::ERR_BITS'(major_twice);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Pixels are checked before the request of the same edge is predicted,
    // so a pixel can only match a step taken at an earlier edge.
    always @(posedge clk)
    begin
        bls_pkg::pix_t want;
        if (rst_n && pix_valid && !pix_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: pixel mismatch: expected none, got x=%0d y=%0d plot=%0b last=%0b",
                         $time, pix.pixel_x, pix.pixel_y, pix.plot, pix.last);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("pixel_x", int'(want.pixel_x), int'(pix.pixel_x));
                check_field("pixel_y", int'(want.pixel_y), int'(pix.pixel_y));
                check_field("plot", int'(want.plot), int'(pix.plot));
                check_field("last", int'(want.last), int'(pix.last));
            end
        end
        if (rst_n && req_valid && !req_stall)
            walk_line(req);
        if (rst_n && cfg_valid && cfg_ready)
            style_q = cfg_data;
    end

    // Pixel receiver: random stall runs, calm stretches, and a long hold on request.
    initial
    begin
        int run;
        pix_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_pix)
            begin
                pix_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pix = 1'b0;
            end
            else if (calm)
            begin
                pix_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                pix_stall <= ($urandom_range(0, 2) == 0);
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
                repeat (run) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic bls_pkg::req_t rand_req(input logic c);
        bls_pkg::req_t r;
        r.cmd = c;
        r.x_start = bls_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
        r.y_start = bls_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
        r.x_end = bls_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
        r.y_end = bls_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
        return r;
    endfunction

    function automatic logic [bls_pkg::COORD_BITS-1:0] base_coord();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? COORD_MAX : '0;
        return bls_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
    endfunction

    function automatic logic [bls_pkg::COORD_BITS-1:0] near(
        input logic [bls_pkg::COORD_BITS-1:0] base,
        input int span);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > int'(COORD_MAX))
            v = int'(COORD_MAX);
        return v[bls_pkg::COORD_BITS-1:0];
    endfunction

    function automatic int pixel_count(input bls_pkg::req_t r);
        int adx, ady;
        adx = int'(r.x_start) - int'(r.x_end);
        ady = int'(r.y_start) - int'(r.y_end);
        if (adx < 0)
            adx = -adx;
        if (ady < 0)
            ady = -ady;
        return ((adx > ady) ? adx : ady) + 1;
    endfunction

    // Valid stays high into the next item when no gap follows.
    task automatic send_req(input bls_pkg::req_t r);
        int gap;
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_line(input logic [bls_pkg::COORD_BITS-1:0] xs,
                             input logic [bls_pkg::COORD_BITS-1:0] ys,
                             input logic [bls_pkg::COORD_BITS-1:0] xe,
                             input logic [bls_pkg::COORD_BITS-1:0] ye,
                             input int steps);
        bls_pkg::req_t r;
        r.cmd = bls_pkg::CMD_LOAD;
        r.x_start = xs;
        r.y_start = ys;
        r.x_end = xe;
        r.y_end = ye;
        send_req(r);
        repeat (steps) send_req(rand_req(bls_pkg::CMD_STEP));
    endtask

    task automatic drain_pixels();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_style(input logic s);
        drain_pixels();
        cfg_data <= s;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_idle_steps();
        send_req(rand_req(bls_pkg::CMD_STEP));
        send_req(rand_req(bls_pkg::CMD_STEP));
    endtask

    task automatic test_directed_lines();
        // A tie between the deltas makes y the major axis.
        send_line(COORD_MAX, '0, '0, COORD_MAX, 3);
        // Reloading mid-line replaces the active walk.
        send_line('0, COORD_MAX, COORD_MAX, COORD_MAX - 1'b1, 2);
        // A single point gives one last pixel; the extra step is ignored.
        send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 2);
        send_line(12'd0, 12'd9, 12'd3, 12'd9, 4);
        send_line(12'd7, 12'd0, 12'd7, 12'd2, 3);
        send_line('0, '0, '0, '0, 1);
    endtask

    task automatic test_dashed_line();
        write_style(bls_pkg::STYLE_DASHED);
        send_line(12'd20, 12'd10, 12'd29, 12'd14, 10);
        // A reload restarts the stipple pattern.
        send_line(12'd5, 12'd5, 12'd0, 12'd0, 3);
        send_line(12'd5, 12'd5, 12'd0, 12'd0, 6);
        write_style(bls_pkg::STYLE_SOLID);
    endtask

    task automatic test_backpressure();
        drain_pixels();
        calm = 1'b1;
        hold_pix = 1'b1;
        send_line(12'd100, 12'd40, 12'd0, 12'd0, 101);
        calm = 1'b0;
        drain_pixels();
    endtask

    task automatic run_random(input int quota);
        int            done;
        int            kind;
        int            span;
        int            pixels;
        bls_pkg::req_t r;
        done = 0;
        while (done < quota)
        begin
            kind = $urandom_range(0, 9);
            calm = ($urandom_range(0, 7) == 0);
            if (kind == 9)
            begin
                r = rand_req(1'($urandom_range(0, 1)));
                send_req(r);
                if (r.cmd == bls_pkg::CMD_LOAD)
                    done++;
            end
            else
            begin
                span = ($urandom_range(0, 19) == 0) ? 300 : 12;
                r = rand_req(bls_pkg::CMD_LOAD);
                r.x_start = base_coord();
                r.y_start = base_coord();
                r.x_end = near(r.x_start, span);
                r.y_end = near(r.y_start, span);
                pixels = pixel_count(r);
                // A broken walk stops early and is cut off by the next load.
                if (kind == 8)
                    pixels = $urandom_range(0, pixels - 1);
                send_req(r);
                repeat (pixels) send_req(rand_req(bls_pkg::CMD_STEP));
                done += 1 + pixels;
                if (kind == 7)
                    repeat ($urandom_range(1, 3)) send_req(rand_req(bls_pkg::CMD_STEP));
            end
        end
        calm = 1'b0;
    endtask

    task automatic test_random();
        write_style(bls_pkg::STYLE_SOLID);
        run_random(270);
        write_style(bls_pkg::STYLE_DASHED);
        run_random(270);
        write_style(bls_pkg::STYLE_SOLID);
        run_random(270);
        write_style(bls_pkg::STYLE_DASHED);
        run_random(270);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_steps();
        test_directed_lines();
        test_dashed_line();
        test_backpressure();
        test_random();
        drain_pixels();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("** bresenham_line_stepper: PASSED **");
        else
            $display("** bresenham_line_stepper: FAILED **");
        $finish;
    end

endmodule

FILE: bresenham_line_stepper.f
rtl/bls_pkg.sv
rtl/bls_walk.sv
rtl/bresenham_line_stepper.sv
test/bresenham_line_stepper_test.sv
